[rtl/lsfh_pkg.sv]
`timescale 1ns / 1ps
// shared types, codes and constants of the lin slave frame handler
package lsfh_pkg;

   localparam int FRAME_DATA_BYTES = 8;
   localparam int RX_COUNT_W       = 4;
   localparam int TICK_W           = 16;
   localparam int BYTE_W           = 8;
   localparam int CSR_DATA_W       = 16;
   localparam int CSR_ADDR_W       = 2;
   localparam int BURST_DEPTH      = 3;
   localparam int BURST_CNT_W      = 2;

   localparam logic [BYTE_W-1:0] SYNC_BYTE = 8'h55;

   typedef enum logic [1:0] {
      EV_TICK = 2'd0,
      EV_FALL = 2'd1,
      EV_RISE = 2'd2,
      EV_BYTE = 2'd3
   } ev_kind_type;

   typedef enum logic [1:0] {
      RSP_DATA      = 2'd0,
      RSP_TX        = 2'd1,
      RSP_BREAK_ERR = 2'd2
   } rsp_kind_type;

   typedef enum logic [1:0] {
      EDGE_FALL = 2'd0,
      EDGE_RISE = 2'd1,
      EDGE_RX   = 2'd2
   } edge_mode_type;

   typedef enum logic [1:0] {
      PH_SYNC = 2'd0,
      PH_ID   = 2'd1,
      PH_DATA = 2'd2
   } frame_phase_type;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_RECEIVE_ID      = 2'd0,
      CSR_SEND_ID         = 2'd1,
      CSR_BREAK_THRESHOLD = 2'd2,
      CSR_DIAG_VALUE      = 2'd3
   } csr_addr_type;

   typedef struct packed {
      logic [BYTE_W-1:0] receive_id;
      logic [BYTE_W-1:0] send_id;
      logic [TICK_W-1:0] break_threshold;
      logic [BYTE_W-1:0] diag_value;
   } cfg_type;

   typedef struct packed {
      rsp_kind_type      result_type;
      logic [BYTE_W-1:0] data_byte;
      logic              last;
   } rsp_beat_type;

   typedef struct packed {
      logic [BURST_CNT_W-1:0]          count;
      rsp_beat_type [BURST_DEPTH-1:0]  beats;
   } burst_type;

endpackage

[rtl/lsfh_csr.sv]
`timescale 1ns / 1ps
// configuration registers of the lin slave frame handler
module lsfh_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [lsfh_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  logic [lsfh_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output lsfh_pkg::cfg_type                cfg
);

   lsfh_pkg::cfg_type cfg_ff;
   lsfh_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (lsfh_pkg::csr_addr_type'(csr_addr))
            lsfh_pkg::CSR_RECEIVE_ID: begin
               cfg_in.receive_id = csr_wdata[lsfh_pkg::BYTE_W-1:0];
            end
            lsfh_pkg::CSR_SEND_ID: begin
               cfg_in.send_id = csr_wdata[lsfh_pkg::BYTE_W-1:0];
            end
            lsfh_pkg::CSR_BREAK_THRESHOLD: begin
               cfg_in.break_threshold = csr_wdata[lsfh_pkg::TICK_W-1:0];
            end
            lsfh_pkg::CSR_DIAG_VALUE: begin
               cfg_in.diag_value = csr_wdata[lsfh_pkg::BYTE_W-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.receive_id      <= 8'd0;
         cfg_ff.send_id         <= 8'd1;
         cfg_ff.break_threshold <= 16'd13;
         cfg_ff.diag_value      <= 8'd170;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[rtl/lsfh_frame.sv]
`timescale 1ns / 1ps
// break detection and frame state machine, one event per cycle while fire is high
module lsfh_frame (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         fire,
   input  lsfh_pkg::ev_kind_type        kind,
   input  logic [lsfh_pkg::BYTE_W-1:0]  rx_byte,
   input  logic [lsfh_pkg::BYTE_W-1:0]  sensor_value,
   input  lsfh_pkg::cfg_type            cfg,
   output lsfh_pkg::burst_type          burst
);

   lsfh_pkg::edge_mode_type              edge_ff, edge_in;
   lsfh_pkg::frame_phase_type            phase_ff, phase_in;
   logic [lsfh_pkg::TICK_W-1:0]          tick_ff, tick_in;
   logic [lsfh_pkg::RX_COUNT_W-1:0]      rx_count_ff, rx_count_in;

   logic [lsfh_pkg::RX_COUNT_W-1:0]      rx_count_inc;
   logic                                 rx_done;
   logic                                 rx_on;
   logic                                 long_low;
   logic [lsfh_pkg::BYTE_W-1:0]          tx_sum;

   assign rx_count_inc = rx_count_ff + 1'b1;
   assign rx_done      = (rx_count_inc == lsfh_pkg::RX_COUNT_W'(lsfh_pkg::FRAME_DATA_BYTES));
   assign rx_on        = (edge_ff != lsfh_pkg::EDGE_FALL) && (edge_ff != lsfh_pkg::EDGE_RISE);
   assign long_low     = (tick_ff > cfg.break_threshold);
   assign tx_sum       = sensor_value + cfg.diag_value;

   // next state
   always_comb begin
      edge_in     = edge_ff;
      phase_in    = phase_ff;
      tick_in     = tick_ff;
      rx_count_in = rx_count_ff;
      unique case (kind)
         lsfh_pkg::EV_TICK: begin
            tick_in = tick_ff + 1'b1;
         end
         lsfh_pkg::EV_FALL: begin
            if (edge_ff == lsfh_pkg::EDGE_FALL) begin
               tick_in = '0;
               edge_in = lsfh_pkg::EDGE_RISE;
            end
         end
         lsfh_pkg::EV_RISE: begin
            if (edge_ff == lsfh_pkg::EDGE_RISE && long_low) begin
               edge_in  = lsfh_pkg::EDGE_RX;
               phase_in = lsfh_pkg::PH_SYNC;
            end
         end
         lsfh_pkg::EV_BYTE: begin
            if (rx_on) begin
               priority case (phase_ff)
                  lsfh_pkg::PH_ID: begin
                     if (rx_byte == cfg.receive_id) begin
                        phase_in = lsfh_pkg::PH_DATA;
                     end else begin
                        phase_in = lsfh_pkg::PH_SYNC;
                        edge_in  = lsfh_pkg::EDGE_FALL;
                     end
                  end
                  lsfh_pkg::PH_DATA: begin
                     if (rx_done) begin
                        rx_count_in = '0;
                        phase_in    = lsfh_pkg::PH_SYNC;
                        edge_in     = lsfh_pkg::EDGE_FALL;
                     end else begin
                        rx_count_in = rx_count_inc;
                     end
                  end
                  default: begin
                     if (rx_byte == lsfh_pkg::SYNC_BYTE) begin
                        phase_in = lsfh_pkg::PH_ID;
                     end
                  end
               endcase
            end
         end
         default: begin
            tick_in = tick_ff;
         end
      endcase
   end

   // result beats
   always_comb begin
      burst       = '0;
      burst.beats = '0;
      unique case (kind)
         lsfh_pkg::EV_RISE: begin
            if (edge_ff == lsfh_pkg::EDGE_RISE && !long_low) begin
               burst.count                = 2'd1;
               burst.beats[0].result_type = lsfh_pkg::RSP_BREAK_ERR;
            end
         end
         lsfh_pkg::EV_BYTE: begin
            if (rx_on) begin
               if (phase_ff == lsfh_pkg::PH_ID && rx_byte != cfg.receive_id
                     && rx_byte == cfg.send_id) begin
                  burst.count                = 2'd3;
                  burst.beats[0].result_type = lsfh_pkg::RSP_TX;
                  burst.beats[0].data_byte   = sensor_value;
                  burst.beats[1].result_type = lsfh_pkg::RSP_TX;
                  burst.beats[1].data_byte   = cfg.diag_value;
                  burst.beats[2].result_type = lsfh_pkg::RSP_TX;
                  burst.beats[2].data_byte   = ~tx_sum;
                  burst.beats[2].last        = 1'b1;
               end else if (phase_ff == lsfh_pkg::PH_DATA) begin
                  burst.count                = 2'd1;
                  burst.beats[0].result_type = lsfh_pkg::RSP_DATA;
                  burst.beats[0].data_byte   = rx_byte;
                  burst.beats[0].last        = rx_done;
               end
            end
         end
         default: begin
            burst.count = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         edge_ff     <= lsfh_pkg::EDGE_FALL;
         phase_ff    <= lsfh_pkg::PH_SYNC;
         tick_ff     <= '0;
         rx_count_ff <= '0;
      end else if (fire) begin
         edge_ff     <= edge_in;
         phase_ff    <= phase_in;
         tick_ff     <= tick_in;
         rx_count_ff <= rx_count_in;
      end
   end

`ifndef SYNTHESIS
   a_rx_count_range: assert property (@(posedge clock) disable iff (reset)
      rx_count_ff < lsfh_pkg::RX_COUNT_W'(lsfh_pkg::FRAME_DATA_BYTES))
      else $error("data byte count out of range");

   a_phase_needs_rx: assert property (@(posedge clock) disable iff (reset)
      (phase_ff != lsfh_pkg::PH_SYNC) |-> rx_on)
      else $error("frame phase advanced while reception off");
`endif

endmodule

[rtl/lsfh_rsp_buf.sv]
`timescale 1ns / 1ps
// result buffer that plays out up to three beats of one event
module lsfh_rsp_buf (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         load,
   input  lsfh_pkg::burst_type          burst,
   output logic                         free,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output lsfh_pkg::rsp_beat_type       rsp_beat
);

   logic [lsfh_pkg::BURST_CNT_W-1:0]          cnt_ff, cnt_in;
   logic [lsfh_pkg::BURST_CNT_W-1:0]          idx_ff, idx_in;
   lsfh_pkg::rsp_beat_type [lsfh_pkg::BURST_DEPTH-1:0] beats_ff, beats_in;

   logic pop;
   logic pop_last;

   assign rsp_tvalid = (cnt_ff != '0);
   assign pop        = rsp_tvalid && rsp_tready;
   assign pop_last   = pop && (idx_ff == cnt_ff - 1'b1);
   assign free       = !rsp_tvalid || pop_last;

   always_comb begin
      unique case (idx_ff)
         2'd0:    rsp_beat = beats_ff[0];
         2'd1:    rsp_beat = beats_ff[1];
         2'd2:    rsp_beat = beats_ff[2];
         default: rsp_beat = beats_ff[0];
      endcase
   end

   always_comb begin
      cnt_in   = cnt_ff;
      idx_in   = idx_ff;
      beats_in = beats_ff;
      if (load && free) begin
         cnt_in   = burst.count;
         idx_in   = '0;
         beats_in = burst.beats;
      end else if (pop_last) begin
         cnt_in = '0;
         idx_in = '0;
      end else if (pop) begin
         idx_in = idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         idx_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
         idx_ff <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      beats_ff <= beats_in;
   end

`ifndef SYNTHESIS
   a_idx_in_burst: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (idx_ff < cnt_ff))
      else $error("beat index beyond burst length");

   a_burst_continues: assert property (@(posedge clock) disable iff (reset)
      (pop && !pop_last) |=> (rsp_tvalid && idx_ff == $past(idx_ff) + 1'b1))
      else $error("burst dropped before its last beat");

   a_load_only_free: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !pop) |=> (cnt_ff == $past(cnt_ff)))
      else $error("pending burst overwritten");
`endif

endmodule

[rtl/lin_slave_frame_handler.sv]
`timescale 1ns / 1ps
// top level of the lin slave frame handler
//
// each req beat is one bus event (tick, falling edge, rising edge or received
// byte); it waits in an input register until the result buffer is free, whose
// registered results drive rsp. events with no or one result are taken at one
// per clock while rsp takes each result at once. a send identifier gives three
// transmit beats, which leave the buffer one per cycle while rsp_tready is high;
// the next event waits in the input register and req is held off until the last
// of them is taken. configuration writes take effect at the next clock edge.
module lin_slave_frame_handler (
   input  logic                                clock,
   input  logic                                reset,
   // slave side
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [15:0]                         req_tdata,   // rx_byte, sensor_value
   input  logic [1:0]                          req_tuser,   // kind
   // master side
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [7:0]                          rsp_tdata,   // data_byte
   output logic [1:0]                          rsp_tuser,   // result_type
   output logic                                rsp_tlast,
   // configuration
   input  logic                                csr_we,
   input  logic [lsfh_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [lsfh_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   logic                          in_valid_ff, in_valid_in;
   lsfh_pkg::ev_kind_type         in_kind_ff;
   logic [lsfh_pkg::BYTE_W-1:0]   in_byte_ff;
   logic [lsfh_pkg::BYTE_W-1:0]   in_sensor_ff;

   lsfh_pkg::cfg_type             cfg;
   lsfh_pkg::burst_type           burst;
   lsfh_pkg::rsp_beat_type        rsp_beat;
   logic                          buf_free;
   logic                          fire;
   logic                          req_take;

   assign fire       = in_valid_ff && buf_free;
   assign req_tready = !in_valid_ff || fire;
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_kind_ff   <= lsfh_pkg::ev_kind_type'(req_tuser);
         in_byte_ff   <= req_tdata[7:0];
         in_sensor_ff <= req_tdata[15:8];
      end
   end

   lsfh_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   lsfh_frame u_frame (
      .clock        (clock),
      .reset        (reset),
      .fire         (fire),
      .kind         (in_kind_ff),
      .rx_byte      (in_byte_ff),
      .sensor_value (in_sensor_ff),
      .cfg          (cfg),
      .burst        (burst)
   );

   lsfh_rsp_buf u_rsp_buf (
      .clock      (clock),
      .reset      (reset),
      .load       (fire),
      .burst      (burst),
      .free       (buf_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_beat   (rsp_beat)
   );

   assign rsp_tdata = rsp_beat.data_byte;
   assign rsp_tuser = 2'(rsp_beat.result_type);
   assign rsp_tlast = rsp_beat.last;

endmodule

[verif/lin_slave_frame_handler_test.sv]
`timescale 1ns / 1ps
// self-checking testbench of the lin slave frame handler with its own frame predictor
module lin_slave_frame_handler_test;
   import lsfh_pkg::*;

   typedef struct {
      ev_kind_type       kind;
      logic [BYTE_W-1:0] rx_byte;
      logic [BYTE_W-1:0] sensor_value;
   } bus_event_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [15:0]           req_tdata = '0;    // rx_byte, sensor_value
   logic [1:0]            req_tuser = '0;    // kind
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [7:0]            rsp_tdata;         // data_byte
   logic [1:0]            rsp_tuser;         // result_type
   logic                  rsp_tlast;
   logic                  csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   bus_event_type pending_events[$];
   rsp_beat_type  expected_beats[$];
   bus_event_type cur_event;
   int            issued_cnt = 0;
   int            accepted_cnt = 0;
   int            mismatch_cnt = 0;
   int            send_idle_pct = 0;
   int            rsp_stall_pct = 0;

   // predictor state
   cfg_type               node_cfg;
   edge_mode_type         line_mode;
   frame_phase_type       frame_ph;
   logic [TICK_W-1:0]     low_ticks;
   logic [RX_COUNT_W-1:0] data_cnt;

   lin_slave_frame_handler u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic void add_expect(input rsp_kind_type kind, input logic [7:0] data,
                                      input logic last);
      rsp_beat_type beat;
      beat.result_type = kind;
      beat.data_byte   = data;
      beat.last        = last;
      expected_beats.push_back(beat);
   endfunction

   function automatic void end_frame();
      frame_ph  = PH_SYNC;
      line_mode = EDGE_FALL;
   endfunction

   function automatic void track_bus_event(input bus_event_type ev);
      logic [BYTE_W-1:0] check_sum;
      case (ev.kind)
         EV_TICK: low_ticks = low_ticks + 1'b1;
         EV_FALL: begin
            if (line_mode == EDGE_FALL) begin
               low_ticks = '0;
               line_mode = EDGE_RISE;
            end
         end
         EV_RISE: begin
            if (line_mode == EDGE_RISE) begin
               if (low_ticks > node_cfg.break_threshold) begin
                  line_mode = EDGE_RX;
                  frame_ph  = PH_SYNC;
               end else begin
                  add_expect(RSP_BREAK_ERR, 8'h00, 1'b0);
               end
            end
         end
         default: begin
            if (line_mode != EDGE_FALL && line_mode != EDGE_RISE) begin
               case (frame_ph)
                  PH_ID: begin
                     if (ev.rx_byte == node_cfg.receive_id) begin
                        frame_ph = PH_DATA;
                     end else if (ev.rx_byte == node_cfg.send_id) begin
                        check_sum = ev.sensor_value + node_cfg.diag_value;
                        add_expect(RSP_TX, ev.sensor_value, 1'b0);
                        add_expect(RSP_TX, node_cfg.diag_value, 1'b0);
                        add_expect(RSP_TX, ~check_sum, 1'b1);
                        end_frame();
                     end else begin
                        end_frame();
                     end
                  end
                  PH_DATA: begin
                     data_cnt = data_cnt + 1'b1;
                     if (data_cnt == FRAME_DATA_BYTES) begin
                        add_expect(RSP_DATA, ev.rx_byte, 1'b1);
                        data_cnt = '0;
                        end_frame();
                     end else begin
                        add_expect(RSP_DATA, ev.rx_byte, 1'b0);
                     end
                  end
                  default: begin
                     if (ev.rx_byte == SYNC_BYTE) frame_ph = PH_ID;
                  end
               endcase
            end
         end
      endcase
   endfunction

   always @(posedge clock) begin : event_driver
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            track_bus_event(cur_event);
            accepted_cnt++;
         end
         if (!req_tvalid || req_tready) begin
            if (pending_events.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               cur_event = pending_events.pop_front();
               req_tvalid <= 1'b1;
               req_tuser  <= cur_event.kind;
               req_tdata  <= {cur_event.sensor_value, cur_event.rx_byte};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : rsp_monitor
      rsp_beat_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
         if (rsp_tvalid && rsp_tready) begin
            if (expected_beats.size() == 0) begin
               $display("%0t: unexpected beat, expected none, actual type %0d byte %02h last %0b",
                        $time, rsp_tuser, rsp_tdata, rsp_tlast);
               mismatch_cnt++;
            end else begin
               want = expected_beats.pop_front();
               if (rsp_tuser !== want.result_type) begin
                  $display("%0t: result_type expected %0d actual %0d",
                           $time, want.result_type, rsp_tuser);
                  mismatch_cnt++;
               end
               if (rsp_tdata !== want.data_byte) begin
                  $display("%0t: data_byte expected %02h actual %02h",
                           $time, want.data_byte, rsp_tdata);
                  mismatch_cnt++;
               end
               if (rsp_tlast !== want.last) begin
                  $display("%0t: last expected %0b actual %0b", $time, want.last, rsp_tlast);
                  mismatch_cnt++;
               end
            end
         end
      end
   end

   task automatic queue_event(input ev_kind_type kind, input logic [7:0] rx_byte,
                              input logic [7:0] sensor_value);
      bus_event_type ev;
      ev.kind         = kind;
      ev.rx_byte      = rx_byte;
      ev.sensor_value = sensor_value;
      pending_events.push_back(ev);
      issued_cnt++;
   endtask

   task automatic queue_ticks(input int n);
      repeat (n) queue_event(EV_TICK, $urandom, $urandom);
   endtask

   task automatic wait_idle();
      while (issued_cnt != accepted_cnt || expected_beats.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_csr(input csr_addr_type addr, input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      case (addr)
         CSR_RECEIVE_ID:      node_cfg.receive_id      = value[BYTE_W-1:0];
         CSR_SEND_ID:         node_cfg.send_id         = value[BYTE_W-1:0];
         CSR_BREAK_THRESHOLD: node_cfg.break_threshold = value;
         default:             node_cfg.diag_value      = value[BYTE_W-1:0];
      endcase
   endtask

   task automatic queue_random_frame();
      int         short_ticks;
      int         pick;
      logic [7:0] junk;
      if ($urandom_range(99) < 20) begin
         repeat ($urandom_range(1, 6))
            queue_event(ev_kind_type'($urandom_range(3)), $urandom, $urandom);
      end else begin
         queue_event(EV_FALL, $urandom, $urandom);
         if (node_cfg.break_threshold > 16'd40) begin
            queue_ticks($urandom_range(12));
            queue_event(EV_RISE, $urandom, $urandom);
         end else begin
            short_ticks = 0;
            if ($urandom_range(99) < 25) begin
               short_ticks = $urandom_range(int'(node_cfg.break_threshold));
               queue_ticks(short_ticks);
               queue_event(EV_RISE, $urandom, $urandom);
            end
            queue_ticks(int'(node_cfg.break_threshold) + $urandom_range(1, 3) - short_ticks);
            queue_event(EV_RISE, $urandom, $urandom);
         end
         repeat ($urandom_range(2)) begin
            junk = $urandom;
            if (junk == SYNC_BYTE) junk = ~junk;
            queue_event(EV_BYTE, junk, $urandom);
         end
         queue_event(EV_BYTE, SYNC_BYTE, $urandom);
         pick = $urandom_range(99);
         if (pick < 40) begin
            queue_event(EV_BYTE, node_cfg.receive_id, $urandom);
            repeat (FRAME_DATA_BYTES) begin
               if ($urandom_range(99) < 15)
                  queue_event(ev_kind_type'($urandom_range(2)), $urandom, $urandom);
               queue_event(EV_BYTE, $urandom, $urandom);
            end
         end else if (pick < 75) begin
            queue_event(EV_BYTE, node_cfg.send_id, $urandom);
         end else begin
            queue_event(EV_BYTE, $urandom, $urandom);
         end
      end
   endtask

   task automatic run_phase(input logic [7:0] rid, input logic [7:0] sid,
                            input logic [15:0] thr, input logic [7:0] diag,
                            input int idle_pct, input int stall_pct, input int n_events);
      int first_cnt;
      wait_idle();
      write_csr(CSR_RECEIVE_ID, {8'h00, rid});
      write_csr(CSR_SEND_ID, {8'h00, sid});
      write_csr(CSR_BREAK_THRESHOLD, thr);
      write_csr(CSR_DIAG_VALUE, {8'h00, diag});
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      first_cnt = issued_cnt;
      while (issued_cnt - first_cnt < n_events) queue_random_frame();
   endtask

   initial begin : main_sequence
      logic [7:0] rid;
      node_cfg.receive_id      = 8'd0;
      node_cfg.send_id         = 8'd1;
      node_cfg.break_threshold = 16'd13;
      node_cfg.diag_value      = 8'd170;
      line_mode = EDGE_FALL;
      frame_ph  = PH_SYNC;
      low_ticks = '0;
      data_cnt  = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset settings: ignored events, break error at threshold and break above it, all three ids
      queue_event(EV_BYTE, SYNC_BYTE, 8'h00);
      queue_event(EV_RISE, 8'hFF, 8'hFF);
      queue_event(EV_FALL, 8'h00, 8'h00);
      queue_event(EV_BYTE, SYNC_BYTE, 8'hFF);
      queue_event(EV_FALL, 8'hFF, 8'h00);
      queue_ticks(13);
      queue_event(EV_RISE, 8'h00, 8'h00);
      queue_event(EV_TICK, 8'h00, 8'h00);
      queue_event(EV_RISE, 8'h00, 8'h00);
      queue_event(EV_BYTE, 8'h7E, 8'h00);
      queue_event(EV_BYTE, SYNC_BYTE, 8'h00);
      queue_event(EV_BYTE, 8'h00, 8'h00);
      queue_event(EV_BYTE, 8'hFF, 8'h00);
      queue_event(EV_FALL, 8'h00, 8'h00);
      queue_event(EV_BYTE, 8'h00, 8'h00);
      queue_event(EV_BYTE, 8'h80, 8'h00);
      queue_event(EV_RISE, 8'h00, 8'h00);
      queue_event(EV_BYTE, 8'h01, 8'h00);
      queue_event(EV_BYTE, 8'h7F, 8'h00);
      queue_event(EV_BYTE, 8'hFE, 8'h00);
      queue_event(EV_BYTE, SYNC_BYTE, 8'h00);
      queue_event(EV_BYTE, 8'hAA, 8'h00);
      queue_event(EV_BYTE, 8'h3C, 8'h00);
      queue_event(EV_FALL, 8'h00, 8'h00);
      queue_ticks(14);
      queue_event(EV_RISE, 8'h00, 8'h00);
      queue_event(EV_BYTE, SYNC_BYTE, 8'h00);
      queue_event(EV_BYTE, 8'h01, 8'hFF);
      queue_event(EV_FALL, 8'h00, 8'h00);
      queue_ticks(14);
      queue_event(EV_RISE, 8'h00, 8'h00);
      queue_event(EV_BYTE, SYNC_BYTE, 8'h00);
      queue_event(EV_BYTE, 8'h02, 8'h00);
      queue_event(EV_BYTE, SYNC_BYTE, 8'h00);

      run_phase(8'hFF, 8'h00, 16'd0, 8'hFF, 55, 0, 20);
      run_phase(8'h3C, 8'h3C, 16'd5, $urandom, 0, 55, 25);
      run_phase($urandom, $urandom, 16'hFFFF, $urandom, 0, 0, 15);
      rid = $urandom;
      run_phase(rid, rid ^ 8'($urandom_range(1, 255)), 16'($urandom_range(20)), $urandom,
                35, 35, 25);
      run_phase(8'h00, 8'hFF, 16'd1, 8'h00, 35, 35, 20);

      wait_idle();
      if (mismatch_cnt == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   initial begin : watchdog
      #10_000_000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule
